/* sv/centered_moving_average_assert.svh */
`ifndef CENTERED_MOVING_AVERAGE_ASSERT_SVH
`define CENTERED_MOVING_AVERAGE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define CMA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define CMA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/cma_pkg.sv */
package cma_pkg;

	localparam int OUT_BITS    = 32;
	localparam int SUM_BITS    = 40;
	localparam int RADIUS_BITS = 6;
	localparam int LEN_BITS    = RADIUS_BITS + 1;
	localparam int DIV_STEP    = 4;
	localparam int DIV_CYCLES  = SUM_BITS / DIV_STEP;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [OUT_BITS-1:0] AVG_NONE = '1;

	// one entry of the queue between front and back
	typedef struct packed {
		logic [SUM_BITS-1:0]    sum;
		logic [LEN_BITS-1:0]    len;
		logic                   has_res;
		logic                   full;
		logic                   last_res;
		logic [RADIUS_BITS-1:0] pend;
	} cmd_t;

endpackage

/* sv/cma_cfg_if.sv */
interface cma_cfg_if import cma_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [RADIUS_BITS-1:0] radius;

	modport source(output valid, radius, input ready);
	modport sink(input valid, radius, output ready);
endinterface

/* sv/cma_stream_if.sv */
interface cma_stream_if import cma_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] sample;
	logic                       last_sample;

	modport source(output valid, sample, last_sample, input ready);
	modport sink(input valid, sample, last_sample, output ready);
endinterface

/* sv/cma_result_if.sv */
interface cma_result_if import cma_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] average;
	logic                       full_window;
	logic                       last_result;

	modport source(output valid, average, full_window, last_result, input ready);
	modport sink(input valid, average, full_window, last_result, output ready);
endinterface

/* sv/cma_ram.sv */
module cma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/cma_front.sv */
module cma_front import cma_pkg::*; #(
	parameter int MAX_RADIUS  = 63,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	cma_stream_if.sink             stream,
	input  logic [RADIUS_BITS-1:0] radius,
	output logic                   push,
	output cmd_t                   cmd,
	input  logic                   q_full,
	output logic                   busy
);

	localparam int AW    = $clog2(2 * MAX_RADIUS + 2);
	localparam int DEPTH = 1 << AW;
	localparam int KW    = $clog2(MAX_RADIUS + 1);

	logic [KW-1:0] k;
	logic [AW-1:0] len;
	logic [AW-1:0] i;
	logic [AW:0]   i_inc;
	logic          accept;
	logic          advance;
	logic          need;

	logic signed [SAMPLE_BITS-1:0] s_raw;
	logic signed [OUT_BITS-1:0]    s_ext;
	logic [OUT_BITS-1:0]           old_word;
	logic signed [SUM_BITS-1:0]    sum_new;

	logic [AW-1:0]              wp_q;
	logic [AW-1:0]              seen_q;
	logic signed [SUM_BITS-1:0] sum_q;

	logic                       vld_s1;
	logic signed [OUT_BITS-1:0] smp_s1;
	logic                       sub_s1;
	logic                       has_res_s1;
	logic                       full_s1;
	logic                       last_res_s1;
	logic                       last_s1;
	logic [KW-1:0]              pend_s1;
	logic [AW-1:0]              len_s1;

	assign k     = (radius > RADIUS_BITS'(MAX_RADIUS)) ? KW'(MAX_RADIUS) : radius[KW-1:0];
	assign len   = AW'({k, 1'b1});
	assign i     = (seen_q > len) ? len : seen_q;
	assign i_inc = {1'b0, i} + (AW + 1)'(1);
	assign s_raw = stream.sample[SAMPLE_BITS-1:0];
	assign s_ext = OUT_BITS'(s_raw);

	assign accept = stream.valid && stream.ready;
	assign need   = has_res_s1 || (pend_s1 != '0);
	assign advance = vld_s1 && (!need || !q_full);
	assign push    = vld_s1 && need && !q_full;
	assign stream.ready = !vld_s1 || advance;
	assign busy    = vld_s1;

	// read the sample leaving the window while writing the new one
	cma_ram #(
		.WIDTH(OUT_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (accept),
		.waddr(wp_q),
		.wdata(s_ext),
		.re   (accept),
		.raddr(wp_q - len),
		.rdata(old_word)
	);

	assign sum_new = sum_q + SUM_BITS'(smp_s1)
		- (sub_s1 ? SUM_BITS'(signed'(old_word)) : SUM_BITS'(0));

	always_comb begin
		cmd.sum      = sum_new;
		cmd.len      = LEN_BITS'(len_s1);
		cmd.has_res  = has_res_s1;
		cmd.full     = full_s1;
		cmd.last_res = last_res_s1;
		cmd.pend     = RADIUS_BITS'(pend_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			seen_q <= '0;
			sum_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
				if (stream.last_sample) begin
					wp_q   <= '0;
					seen_q <= '0;
				end else begin
					wp_q   <= wp_q + AW'(1);
					seen_q <= (i_inc > {1'b0, len}) ? len : i_inc[AW-1:0];
				end
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				sum_q <= last_s1 ? '0 : sum_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_s1      <= s_ext;
			sub_s1      <= i >= len;
			has_res_s1  <= i >= AW'(k);
			full_s1     <= i >= AW'({k, 1'b0});
			last_res_s1 <= stream.last_sample && (k == '0);
			last_s1     <= stream.last_sample;
			len_s1      <= len;
			if (stream.last_sample) begin
				pend_s1 <= (i_inc < (AW + 1)'(k)) ? i_inc[KW-1:0] : k;
			end else begin
				pend_s1 <= '0;
			end
		end
	end

endmodule

/* sv/cma_queue.sv */
module cma_queue import cma_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;

	assign full  = cnt_q == (PW + 1)'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_cmd;
		end
	end

endmodule

/* sv/cma_back.sv */
module cma_back import cma_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t head,
	input  logic empty,
	output logic pop,
	cma_result_if.source result
);

	localparam int CW = $clog2(DIV_CYCLES);

	typedef enum logic [3:0] {
		BK_IDLE  = 4'b0001,
		BK_DIV   = 4'b0010,
		BK_OUT   = 4'b0100,
		BK_FLUSH = 4'b1000
	} bk_state_t;

	bk_state_t state_q;

	logic [OUT_BITS-1:0]    val_q;
	logic                   full_q;
	logic                   last_res_q;
	logic [RADIUS_BITS-1:0] pend_q;
	logic [SUM_BITS-1:0]    num_q;
	logic [LEN_BITS:0]      rem_q;
	logic [LEN_BITS-1:0]    div_q;
	logic                   neg_q;
	logic [CW-1:0]          cnt_q;

	logic                   ovalid_q;
	logic [OUT_BITS-1:0]    oavg_q;
	logic                   ofull_q;
	logic                   olast_q;

	logic                slot_free;
	logic                load;
	logic [SUM_BITS-1:0] num_nx;
	logic [LEN_BITS:0]   rem_nx;
	logic [SUM_BITS-1:0] quo;

	assign slot_free = !ovalid_q || result.ready;
	assign load      = slot_free && (state_q inside {BK_OUT, BK_FLUSH});
	assign pop       = (state_q == BK_IDLE) && !empty;

	assign result.valid       = ovalid_q;
	assign result.average     = oavg_q;
	assign result.full_window = ofull_q;
	assign result.last_result = olast_q;

	// restoring division of the magnitude, DIV_STEP quotient bits per cycle
	always_comb begin
		logic [LEN_BITS:0]   r;
		logic [SUM_BITS-1:0] n;
		r = rem_q;
		n = num_q;
		for (int j = 0; j < DIV_STEP; j++) begin
			r = {r[LEN_BITS-1:0], n[SUM_BITS-1]};
			n = {n[SUM_BITS-2:0], 1'b0};
			if (r >= {1'b0, div_q}) begin
				r    = r - {1'b0, div_q};
				n[0] = 1'b1;
			end
		end
		rem_nx = r;
		num_nx = n;
	end

	assign quo = neg_q ? (SUM_BITS'(0) - num_nx) : num_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (result.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (!empty) begin
						if (head.has_res && head.full) begin
							state_q <= BK_DIV;
						end else if (head.has_res) begin
							state_q <= BK_OUT;
						end else begin
							state_q <= BK_FLUSH;
						end
					end
				end
				BK_DIV: begin
					if (cnt_q == CW'(DIV_CYCLES - 1)) begin
						state_q <= BK_OUT;
					end
				end
				BK_OUT: begin
					if (slot_free) begin
						state_q <= (pend_q != '0) ? BK_FLUSH : BK_IDLE;
					end
				end
				BK_FLUSH: begin
					if (slot_free && pend_q == RADIUS_BITS'(1)) begin
						state_q <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				full_q     <= head.full;
				last_res_q <= head.last_res;
				pend_q     <= head.pend;
				div_q      <= head.len;
				neg_q      <= head.sum[SUM_BITS-1];
				num_q      <= head.sum[SUM_BITS-1] ? (SUM_BITS'(0) - head.sum) : head.sum;
				rem_q      <= '0;
				cnt_q      <= '0;
				val_q      <= AVG_NONE;
			end
			BK_DIV: begin
				num_q <= num_nx;
				rem_q <= rem_nx;
				cnt_q <= cnt_q + CW'(1);
				val_q <= quo[OUT_BITS-1:0];
			end
			BK_OUT: begin
				if (slot_free) begin
					oavg_q  <= val_q;
					ofull_q <= full_q;
					olast_q <= last_res_q;
				end
			end
			BK_FLUSH: begin
				if (slot_free) begin
					oavg_q  <= AVG_NONE;
					ofull_q <= 1'b0;
					olast_q <= pend_q == RADIUS_BITS'(1);
					pend_q  <= pend_q - RADIUS_BITS'(1);
				end
			end
			default: begin
				val_q <= AVG_NONE;
			end
		endcase
	end

endmodule

/* sv/centered_moving_average.sv */
// Path: a full-window mean passes the sum stage, the queue pop, the radix-16 divider and
// the output load; a -1 result skips the divider. The back end pops a new entry only
// after the current one is loaded. Throughput: samples enter one per cycle while the
// queue has room; flush results leave one per cycle while the receiver is ready.
// Reset (arst_n, async): radius goes to 1, sum/count/pointer clear; the sample ring is
// not cleared, entries are only read after being written in the current stream.
module centered_moving_average import cma_pkg::*; #(
	parameter int MAX_RADIUS  = 63,
	parameter int SAMPLE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	cma_cfg_if.sink       cfg,
	cma_stream_if.sink    stream,
	cma_result_if.source  result
);

	`include "centered_moving_average_assert.svh"

	logic [RADIUS_BITS-1:0] radius_q;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	cmd_t q_in;
	cmd_t q_head;
	logic fe_busy;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_BITS'(1);
		end else if (cfg.valid && cfg.ready) begin
			radius_q <= cfg.radius;
		end
	end

	cma_front #(
		.MAX_RADIUS (MAX_RADIUS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.stream(stream),
		.radius(radius_q),
		.push  (q_push),
		.cmd   (q_in),
		.q_full(q_full),
		.busy  (fe_busy)
	);

	cma_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_in),
		.full    (q_full),
		.pop     (q_pop),
		.head    (q_head),
		.empty   (q_empty)
	);

	cma_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (q_head),
		.empty (q_empty),
		.pop   (q_pop),
		.result(result)
	);

	`CMA_ASSERT_IMP(a_push_room, q_push, !q_full, "item pushed into a full queue")
	`CMA_ASSERT_IMP(a_pop_data, q_pop, !q_empty, "item popped from an empty queue")
	`CMA_ASSERT_NXT(a_push_lands, q_push && !q_pop, !q_empty, "pushed item missing from queue")
	`CMA_ASSERT_IMP(a_stall_cause, !stream.ready, fe_busy, "input stalled with front stage empty")

endmodule

/* dv/cma_checker.sv */
`timescale 1ns / 100ps

module cma_checker import cma_pkg::*; #(
	parameter int MAX_RADIUS = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	cma_cfg_if          cfg,
	cma_stream_if       stream,
	cma_result_if       result,
	output int unsigned errors,
	output int unsigned pending
);

	localparam int RING_DEPTH   = 128;
	localparam int RADIUS_RESET = 1;
	localparam int SHOW_LIMIT   = 10;

	typedef struct packed {
		logic [OUT_BITS-1:0] average;
		logic                full_window;
		logic                last_result;
	} mean_t;

	mean_t                  mean_due[$];
	logic [OUT_BITS-1:0]    ring [RING_DEPTH];
	logic [SUM_BITS-1:0]    acc;
	int unsigned            seen;
	logic [6:0]             wp;
	logic [RADIUS_BITS-1:0] radius_q;

	function automatic void push_mean(logic [OUT_BITS-1:0] avg, logic full, logic fin);
		mean_t m;
		m = '{average: avg, full_window: full, last_result: fin};
		mean_due = {mean_due, m};
	endfunction

	// one accepted sample: update the window and queue every item it releases
	task automatic take_sample(logic [OUT_BITS-1:0] s, logic fin);
		int unsigned k, len, i, pend;
		logic [6:0]  old_idx;
		longint      quo;
		k   = (radius_q > MAX_RADIUS) ? MAX_RADIUS : radius_q;
		len = 2 * k + 1;
		i   = (seen > len) ? len : seen;
		ring[wp] = s;
		acc = acc + {{(SUM_BITS-OUT_BITS){s[OUT_BITS-1]}}, s};
		if (i >= len) begin
			old_idx = wp - 7'(len);
			acc = acc - {{(SUM_BITS-OUT_BITS){ring[old_idx][OUT_BITS-1]}}, ring[old_idx]};
		end
		wp   = wp + 7'd1;
		seen = (i + 1 > len) ? len : i + 1;
		if (i >= k) begin
			if (i >= 2 * k) begin
				// signed division truncates toward zero; wide quotients are cut to 32 bits
				quo = longint'(signed'(acc)) / longint'(len);
				push_mean(quo[OUT_BITS-1:0], 1'b1, fin && k == 0);
			end else
				push_mean(AVG_NONE, 1'b0, fin && k == 0);
		end
		if (fin) begin
			pend = (i + 1 < k) ? i + 1 : k;
			for (int unsigned j = 0; j < pend; j++)
				push_mean(AVG_NONE, 1'b0, j + 1 == pend);
			acc  = '0;
			seen = 0;
			wp   = '0;
		end
	endtask

	task automatic check_result();
		mean_t want;
		if (mean_due.size() == 0) begin
			errors++;
			if (errors <= SHOW_LIMIT)
				$display("%0t: unexpected item: average %0d full %b last %b", $realtime,
					$signed(result.average), result.full_window, result.last_result);
		end else begin
			want = mean_due.pop_front();
			if (result.average !== want.average || result.full_window !== want.full_window ||
					result.last_result !== want.last_result) begin
				errors++;
				if (errors <= SHOW_LIMIT)
					$display("%0t: mismatch: expected average %0d full %b last %b, got %0d %b %b",
						$realtime, $signed(want.average), want.full_window, want.last_result,
						$signed(result.average), result.full_window, result.last_result);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc      = '0;
			seen     = 0;
			wp       = '0;
			radius_q = RADIUS_BITS'(RADIUS_RESET);
			mean_due.delete();
		end else begin
			if (cfg.valid && cfg.ready)
				radius_q = cfg.radius;
			if (stream.valid && stream.ready)
				take_sample(stream.sample, stream.last_sample);
			if (result.valid && result.ready)
				check_result();
		end
		pending <= mean_due.size();
	end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
	import cma_pkg::*;

	localparam int SETTLE      = 40;
	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 2000;
	localparam int RAND_ITEMS  = 170;
	localparam int MAX_GAP     = 11;

	localparam logic [OUT_BITS-1:0] S_MAX = 32'h7FFF_FFFF;
	localparam logic [OUT_BITS-1:0] S_MIN = 32'h8000_0000;

	logic        clk = 1'b0;
	logic        arst_n;
	bit          pace;
	bit          rx_hold;
	int unsigned errors;
	int unsigned pending;

	cma_cfg_if    cfg_ch();
	cma_stream_if smp_ch();
	cma_result_if res_ch();

	centered_moving_average u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.stream (smp_ch),
		.result (res_ch)
	);

	cma_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.stream  (smp_ch),
		.result  (res_ch),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [OUT_BITS-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return S_MAX;
			1: return S_MIN;
			2: return OUT_BITS'($urandom_range(0, 20)) - OUT_BITS'(10);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_sample(logic [OUT_BITS-1:0] s, logic fin);
		int unsigned gap;
		gap = pace ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			smp_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_ch.valid       <= 1'b1;
		smp_ch.sample      <= s;
		smp_ch.last_sample <= fin;
		do @(posedge clk); while (smp_ch.ready !== 1'b1);
	endtask

	task automatic send_stream(int unsigned n, logic close);
		for (int unsigned j = 0; j < n; j++)
			send_sample(pick_sample(), close && j == n - 1);
	endtask

	// stop offering, let every expected item drain, then give the divider time
	task automatic quiesce();
		smp_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_radius(logic [RADIUS_BITS-1:0] r);
		quiesce();
		cfg_ch.valid  <= 1'b1;
		cfg_ch.radius <= r;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : rx_drive
		int unsigned gap;
		res_ch.ready <= 1'b0;
		@(posedge clk iff arst_n === 1'b1);
		forever begin
			gap = pace ? $urandom_range(0, MAX_GAP) : 0;
			if (gap > 0 || rx_hold) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (rx_hold) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((cfg_ch.valid && cfg_ch.ready) || (smp_ch.valid && smp_ch.ready) ||
					(res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[centered_moving_average] ERROR");
		$finish;
	end

	initial begin : stim
		logic [RADIUS_BITS-1:0] r;
		int unsigned            n, cut, n_rand;
		arst_n             <= 1'b0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.radius      <= '0;
		smp_ch.valid       <= 1'b0;
		smp_ch.sample      <= '0;
		smp_ch.last_sample <= 1'b0;
		rx_hold            <= 1'b0;
		pace = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// radius straight out of reset
		send_sample(100, 1'b0);
		send_sample(-7, 1'b0);
		send_sample(S_MAX, 1'b1);

		// zero radius: every sample is its own full mean
		set_radius('0);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(-1, 1'b0);
		send_sample(0, 1'b0);
		send_sample(5, 1'b1);

		// streams shorter than the window, then rounding of a negative mean
		set_radius(2);
		send_sample(3, 1'b0);
		send_sample(4, 1'b1);
		send_sample(9, 1'b1);
		send_sample(-7, 1'b0);
		repeat (4) send_sample(0, 1'b0);
		send_sample(-3, 1'b1);

		set_radius('1);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(1, 1'b1);

		// shrink the window mid-stream so the mean no longer fits in 32 bits
		set_radius(1);
		repeat (3) send_sample(S_MAX, 1'b0);
		set_radius('0);
		send_sample(S_MAX, 1'b1);

		// receiver holds off while the sender streams back to back
		pace = 1'b0;
		set_radius(2);
		fork
			begin
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		send_stream(40, 1'b1);
		// directed samples so far, the long stream included
		n_rand = 64;

		while (n_rand < RAND_ITEMS) begin
			pace = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 7))
				0: r = '1;
				1: r = RADIUS_BITS'($urandom_range(8, 62));
				default: r = RADIUS_BITS'($urandom_range(0, 7));
			endcase
			set_radius(r);
			repeat ($urandom_range(1, 3)) begin
				if (n_rand < RAND_ITEMS) begin
					n = (r > 7) ? $urandom_range(1, 2 * r + 9) : $urandom_range(1, 6 * r + 7);
					if (n > RAND_ITEMS - n_rand)
						n = RAND_ITEMS - n_rand;
					cut = ($urandom_range(0, 4) == 0) ? n / 2 : 0;
					if (cut > 0) begin
						send_stream(cut, 1'b0);
						set_radius(RADIUS_BITS'($urandom_range(0, 7)));
						send_stream(n - cut, 1'b1);
					end else
						send_stream(n, 1'b1);
					n_rand += n;
				end
			end
		end

		quiesce();
		if (errors == 0 && pending == 0)
			$display("[centered_moving_average] OK");
		else
			$display("[centered_moving_average] ERROR");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/cma_pkg.sv
sv/cma_cfg_if.sv
sv/cma_stream_if.sv
sv/cma_result_if.sv
sv/cma_ram.sv
sv/cma_front.sv
sv/cma_queue.sv
sv/cma_back.sv
sv/centered_moving_average.sv
dv/cma_checker.sv
dv/tb.sv
